// ===== src/rsa_pkg.sv =====
`default_nettype none

package rsa_pkg;

  // Field widths of the command and result transactions.
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 4;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DEPTH_OUT_W = 5;
  localparam int unsigned OUT_TDATA_W = DATA_W + STATUS_W + DEPTH_OUT_W;

  // Default number of stack entries.
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Command codes; the codes above OP_SWAP are unknown.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 4'd0,
    OP_SHOW  = 4'd1,
    OP_DUMP  = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_MUL   = 4'd5,
    OP_DIV   = 4'd6,
    OP_GT    = 4'd7,
    OP_LT    = 4'd8,
    OP_GE    = 4'd9,
    OP_LE    = 4'd10,
    OP_EQ    = 4'd11,
    OP_SWAP  = 4'd12
  } op_e;

  // Completion status reported with every result.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZ    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

endpackage

`default_nettype wire

// ===== src/rpn_stack_alu_unit.sv =====
`default_nettype none

// Channel    | Direction | Signals                   | Contents
// -----------+-----------+---------------------------+-------------------------------------
// Command    | in        | s_axis_tvalid/tready      | tdata: push_value; tuser: op
// Result     | out       | m_axis_tvalid/tready      | tdata: popped_value, status,
//            |           |                           | depth_now; tuser: value_valid
//
// One command is handled at a time. Push, overflow, underflow and unknown codes pass from the
// accepting state straight to loading the output register; print and dump first read the top
// entry; add, subtract, the comparisons and a division by zero read both entries and execute;
// multiply and swap add a write-back state; divide runs 32 restoring steps, then writes back.
// Reset clears the stack count and the sequencer; the stack memory itself is not cleared.
// The next command is taken while the previous result still waits in the output register;
// only a second finished result waits for the result channel to drain.

module rpn_stack_alu_unit #(
  parameter int unsigned STACK_DEPTH = rsa_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command channel.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rsa_pkg::DATA_W-1:0]        s_axis_tdata,   // [31:0] push_value
  input  logic [rsa_pkg::OP_W-1:0]          s_axis_tuser,   // [3:0] op
  // Result channel.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rsa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [31:0] popped_value,
                                                            // [34:32] status,
                                                            // [39:35] depth_now
  output logic [0:0]                        m_axis_tuser    // [0] value_valid
);

  localparam int unsigned DW      = rsa_pkg::DATA_W;
  localparam int unsigned IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DOUT_W  = rsa_pkg::DEPTH_OUT_W;
  localparam int unsigned EXT_W   = (CNT_W > DOUT_W) ? CNT_W : DOUT_W;
  localparam int unsigned STEP_W  = $clog2(DW);

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_GET_T   = 4'd1;
  localparam logic [3:0] S_GET_S   = 4'd2;
  localparam logic [3:0] S_EXEC    = 4'd3;
  localparam logic [3:0] S_MUL_WB  = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_DIV_WB  = 4'd6;
  localparam logic [3:0] S_SWAP_WB = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  rsa_pkg::op_e            op_q, op_d;
  rsa_pkg::op_e            in_op;
  logic [DW-1:0]           t_q, t_d, s_q, s_d;
  logic [DW-1:0]           prod_q, prod_d;
  logic [DW-1:0]           rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic                    neg_q, neg_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [DW-1:0]           res_pop_q, res_pop_d;
  logic                    res_vv_q, res_vv_d;
  rsa_pkg::status_e        res_st_q, res_st_d;
  logic                    m_valid_q, m_valid_d;
  logic [rsa_pkg::OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic                    m_user_q, m_user_d;

  // Stack memory with one shared port; read data is registered and arrives in the cycle after the read.
  logic [DW-1:0]           mem [STACK_DEPTH];
  logic [DW-1:0]           rdata_q;
  logic                    mem_re, mem_we;
  logic [IDX_W-1:0]        mem_raddr, mem_waddr;
  logic [DW-1:0]           mem_wdata;

  logic [CNT_W-1:0]        cnt_m1, cnt_m2;
  logic [EXT_W-1:0]        cnt_ext;
  logic [DW-1:0]           alu_res, abs_t, abs_s;
  logic [DW:0]             div_shift, div_diff;
  logic                    div_ge;

  assign in_op   = rsa_pkg::op_e'(s_axis_tuser);
  assign cnt_m1  = count_q - CNT_W'(1);
  assign cnt_m2  = count_q - CNT_W'(2);
  assign cnt_ext = EXT_W'(count_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Combinational operations on the top entry T and the second entry S.
  always_comb begin
    case (op_q) inside
      rsa_pkg::OP_ADD: alu_res = s_q + t_q;
      rsa_pkg::OP_SUB: alu_res = s_q - t_q;
      rsa_pkg::OP_GT:  alu_res = DW'($signed(t_q) >  $signed(s_q));
      rsa_pkg::OP_LT:  alu_res = DW'($signed(t_q) <  $signed(s_q));
      rsa_pkg::OP_GE:  alu_res = DW'($signed(t_q) >= $signed(s_q));
      rsa_pkg::OP_LE:  alu_res = DW'($signed(t_q) <= $signed(s_q));
      rsa_pkg::OP_EQ:  alu_res = DW'(t_q == s_q);
      default:         alu_res = '0;
    endcase
  end

  // Magnitudes for the divider; the most negative value maps onto its own bit pattern,
  // which is the correct unsigned magnitude.
  assign abs_t = t_q[DW-1] ? (~t_q + DW'(1)) : t_q;
  assign abs_s = s_q[DW-1] ? (~s_q + DW'(1)) : s_q;

  // One restoring division step.
  assign div_shift = {rem_q, quo_q[DW-1]};
  assign div_diff  = div_shift - {1'b0, den_q};
  assign div_ge    = (div_shift >= {1'b0, den_q});

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    op_d      = op_q;
    t_d       = t_q;
    s_d       = s_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    den_d     = den_q;
    neg_d     = neg_q;
    step_d    = step_q;
    res_pop_d = res_pop_q;
    res_vv_d  = res_vv_q;
    res_st_d  = res_st_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mem_re    = 1'b0;
    mem_raddr = cnt_m1[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = cnt_m2[IDX_W-1:0];
    mem_wdata = alu_res;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d      = in_op;
          res_pop_d = '0;
          res_vv_d  = 1'b0;
          res_st_d  = rsa_pkg::ST_OK;
          state_d   = S_DONE;
          case (in_op) inside
            rsa_pkg::OP_PUSH: begin
              if (count_q == CNT_W'(STACK_DEPTH)) begin
                res_st_d = rsa_pkg::ST_OVER;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IDX_W-1:0];
                mem_wdata = s_axis_tdata;
                count_d   = count_q + CNT_W'(1);
              end
            end
            rsa_pkg::OP_SHOW, rsa_pkg::OP_DUMP: begin
              if (count_q == '0) begin
                res_st_d = rsa_pkg::ST_UNDER;
              end else begin
                mem_re  = 1'b1;
                state_d = S_GET_T;
              end
            end
            rsa_pkg::OP_ADD, rsa_pkg::OP_SUB, rsa_pkg::OP_MUL, rsa_pkg::OP_DIV,
            rsa_pkg::OP_GT, rsa_pkg::OP_LT, rsa_pkg::OP_GE, rsa_pkg::OP_LE,
            rsa_pkg::OP_EQ, rsa_pkg::OP_SWAP: begin
              if (count_q < CNT_W'(2)) begin
                res_st_d = rsa_pkg::ST_UNDER;
              end else begin
                mem_re  = 1'b1;
                state_d = S_GET_T;
              end
            end
            default: begin
              res_st_d = rsa_pkg::ST_UNKNOWN;
            end
          endcase
        end
      end
      S_GET_T: begin
        t_d = rdata_q;
        if (op_q == rsa_pkg::OP_SHOW || op_q == rsa_pkg::OP_DUMP) begin
          res_pop_d = rdata_q;
          res_vv_d  = 1'b1;
          count_d   = cnt_m1;
          state_d   = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cnt_m2[IDX_W-1:0];
          state_d   = S_GET_S;
        end
      end
      S_GET_S: begin
        s_d     = rdata_q;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        case (op_q) inside
          rsa_pkg::OP_MUL: begin
            prod_d  = t_q * s_q;
            state_d = S_MUL_WB;
          end
          rsa_pkg::OP_DIV: begin
            if (t_q == '0) begin
              res_st_d = rsa_pkg::ST_DIVZ;
              state_d  = S_DONE;
            end else begin
              den_d   = abs_t;
              quo_d   = abs_s;
              rem_d   = '0;
              neg_d   = t_q[DW-1] ^ s_q[DW-1];
              step_d  = '0;
              state_d = S_DIV;
            end
          end
          rsa_pkg::OP_SWAP: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m1[IDX_W-1:0];
            mem_wdata = s_q;
            state_d   = S_SWAP_WB;
          end
          default: begin
            mem_we  = 1'b1;
            count_d = cnt_m1;
            state_d = S_DONE;
          end
        endcase
      end
      S_MUL_WB: begin
        mem_we    = 1'b1;
        mem_wdata = prod_q;
        count_d   = cnt_m1;
        state_d   = S_DONE;
      end
      S_DIV: begin
        rem_d  = div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
        quo_d  = {quo_q[DW-2:0], div_ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DW - 1)) begin
          state_d = S_DIV_WB;
        end
      end
      S_DIV_WB: begin
        mem_we    = 1'b1;
        mem_wdata = neg_q ? (~quo_q + DW'(1)) : quo_q;
        count_d   = cnt_m1;
        state_d   = S_DONE;
      end
      S_SWAP_WB: begin
        mem_we    = 1'b1;
        mem_wdata = t_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {cnt_ext[DOUT_W-1:0], res_st_q, res_pop_q};
          m_user_d  = res_vv_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    t_q       <= t_d;
    s_q       <= s_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
    step_q    <= step_d;
    res_pop_q <= res_pop_d;
    res_vv_q  <= res_vv_d;
    res_st_q  <= res_st_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  // The stack never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond capacity");

  // Writes land on a live entry or, for a push, on the first free one.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> CNT_W'(mem_waddr) <= count_q)
    else $error("stack write above the top of stack");

  // The single memory port is never asked for a read and a write together.
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("read and write on the shared memory port");

  // The divider is never started with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (den_q != '0))
    else $error("divider running with a zero divisor");

  // A command changes the depth by at most one entry.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q - $past(count_q)) == CNT_W'(1) || ($past(count_q) - count_q) == CNT_W'(1)))
    else $error("stack count jumped by more than one");

endmodule

`default_nettype wire
